// File: rtl/ptik_pkg.sv
// Shared types, constants and helpers of the two-link planar IK block.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package ptik_pkg;

    localparam int ATAN_TABLE_LEN    = 24;
    localparam int DEF_CORDIC_STAGES = 16;
    localparam int NORM_CELLS        = 5;   // shift steps 16, 8, 4, 2, 1
    localparam int NORM_TOP          = 30;  // magnitudes end in [2^29, 2^30)
    localparam int SQRT_CELLS        = 31;  // one root bit per cell
    localparam int ARG_W             = 49;  // signed atan2 arguments
    localparam int MAG_W             = 49;
    localparam int CX_W              = 34;  // CORDIC x/y
    localparam int ANG_W             = 36;  // Q30 angle accumulator
    localparam int REM_W             = 34;
    localparam int ROOT_W            = 31;
    localparam int RAD_W             = 62;

    localparam logic [14:0] LINK_RESET = 15'd256;

    localparam logic [2:0] KIND_UNREACH = 3'd0;
    localparam logic [2:0] KIND_STRETCH = 3'd1;
    localparam logic [2:0] KIND_FOLDED  = 3'd2;
    localparam logic [2:0] KIND_ORIGIN  = 3'd3;
    localparam logic [2:0] KIND_TWO     = 3'd4;

    localparam logic CFG_LINK_FIRST  = 1'b0;
    localparam logic CFG_LINK_SECOND = 1'b1;

    localparam logic signed [ANG_W-1:0] PI_Q30       = 36'sd3373259426;
    localparam logic signed [15:0]      ELBOW_PI_Q13 = 16'sd25736;

    localparam logic [29:0] ATAN_Q30 [0:ATAN_TABLE_LEN-1] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
        30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
        30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
        30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F
    };

    typedef struct packed {
        logic [MAG_W-1:0]        ax;
        logic [MAG_W-1:0]        ay;
        logic                    ny;
        logic signed [ANG_W-1:0] z;
        logic                    zero;
    } norm_t;

    typedef struct packed {
        logic signed [CX_W-1:0]  x;
        logic signed [CX_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
        logic                    zero;
    } cst_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  v;
    } sq_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [33:0] n;
        logic [30:0]        d;
    } side_t;

    // Q30 -> Q13, half away from zero
    function automatic logic [16:0] round_q13(input logic signed [ANG_W:0] a);
        logic [ANG_W:0] mag;
        logic [ANG_W:0] q;
        logic [16:0]    q17;
        begin
            mag = a[ANG_W] ? $unsigned(-a) : $unsigned(a);
            q   = (mag + (ANG_W+1)'(65536)) >> 17;
            q17 = q[16:0];
            round_q13 = a[ANG_W] ? 17'(-q17) : q17;
        end
    endfunction

endpackage

// File: rtl/ptik_sqrt_cell.sv
// One restoring square-root cell: brings in two radicand bits, decides one root bit.
// Depends on ptik_pkg (sq_t, widths).
module ptik_sqrt_cell (
    input  logic           aclk,
    input  logic           en,
    input  ptik_pkg::sq_t  d_in,
    output ptik_pkg::sq_t  d_out
);
    logic [ptik_pkg::REM_W+1:0] rem_w;
    logic [ptik_pkg::REM_W+1:0] trial;
    logic [ptik_pkg::REM_W+1:0] diff;
    ptik_pkg::sq_t sq_next;
    ptik_pkg::sq_t sq_reg;

    always_comb begin
        rem_w     = {d_in.rem, d_in.v[ptik_pkg::RAD_W-1 -: 2]};
        trial     = (ptik_pkg::REM_W+2)'({d_in.root, 2'b01});
        diff      = rem_w - trial;
        sq_next.v = {d_in.v[ptik_pkg::RAD_W-3:0], 2'b00};
        if (rem_w >= trial) begin
            sq_next.rem  = diff[ptik_pkg::REM_W-1:0];
            sq_next.root = {d_in.root[ptik_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            sq_next.rem  = rem_w[ptik_pkg::REM_W-1:0];
            sq_next.root = {d_in.root[ptik_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg <= sq_next;
        end
    end

    assign d_out = sq_reg;
endmodule

// File: rtl/ptik_norm_cell.sv
// One normalize cell: shifts both magnitudes by SHIFT toward [2^29, 2^30).
// Depends on ptik_pkg (norm_t, NORM_TOP).
module ptik_norm_cell #(
    parameter int SHIFT = 1
) (
    input  logic            aclk,
    input  logic            en,
    input  ptik_pkg::norm_t d_in,
    output ptik_pkg::norm_t d_out
);
    logic [ptik_pkg::MAG_W-1:0] mag;
    ptik_pkg::norm_t nrm_next;
    ptik_pkg::norm_t nrm_reg;

    always_comb begin
        mag      = (d_in.ax > d_in.ay) ? d_in.ax : d_in.ay;
        nrm_next = d_in;
        // top bit at 29 + SHIFT or above: a full SHIFT step right is still needed
        if ((mag >> (ptik_pkg::NORM_TOP - 1 + SHIFT)) != '0) begin
            nrm_next.ax = d_in.ax >> SHIFT;   // truncating
            nrm_next.ay = d_in.ay >> SHIFT;
        end else if ((mag >> (ptik_pkg::NORM_TOP - SHIFT)) == '0) begin
            nrm_next.ax = d_in.ax << SHIFT;
            nrm_next.ay = d_in.ay << SHIFT;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nrm_reg <= nrm_next;
        end
    end

    assign d_out = nrm_reg;
endmodule

// File: rtl/ptik_cordic_cell.sv
// One CORDIC vectoring cell, iteration IDX, floor shifts.
// Depends on ptik_pkg (cst_t, ATAN_Q30).
module ptik_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic           aclk,
    input  logic           en,
    input  ptik_pkg::cst_t d_in,
    output ptik_pkg::cst_t d_out
);
    logic signed [ptik_pkg::CX_W-1:0]  xs;
    logic signed [ptik_pkg::CX_W-1:0]  ys;
    logic signed [ptik_pkg::ANG_W-1:0] step;
    ptik_pkg::cst_t cst_next;
    ptik_pkg::cst_t cst_reg;

    always_comb begin
        xs            = $signed(d_in.x) >>> IDX;
        ys            = $signed(d_in.y) >>> IDX;
        step          = $signed(ptik_pkg::ANG_W'(ptik_pkg::ATAN_Q30[IDX]));
        cst_next.zero = d_in.zero;
        if ($signed(d_in.y) > 0) begin
            cst_next.x = $signed(d_in.x) + ys;
            cst_next.y = $signed(d_in.y) - xs;
            cst_next.z = $signed(d_in.z) + step;
        end else begin
            cst_next.x = $signed(d_in.x) - ys;
            cst_next.y = $signed(d_in.y) + xs;
            cst_next.z = $signed(d_in.z) - step;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cst_reg <= cst_next;
        end
    end

    assign d_out = cst_reg;
endmodule

// File: rtl/ptik_atan2.sv
// Pipelined atan2 in Q30: fold stage, normalize cells, CORDIC cells.
// Depends on ptik_pkg, ptik_norm_cell, ptik_cordic_cell.
module ptik_atan2 #(
    parameter int STAGES = ptik_pkg::DEF_CORDIC_STAGES
) (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [ptik_pkg::ARG_W-1:0]  y_in,
    input  logic signed [ptik_pkg::ARG_W-1:0]  x_in,
    output logic signed [ptik_pkg::ANG_W-1:0]  z_out
);
    logic signed [ptik_pkg::ARG_W-1:0] xf;
    logic signed [ptik_pkg::ARG_W-1:0] yf;
    logic signed [ptik_pkg::CX_W-1:0]  mx;
    logic signed [ptik_pkg::CX_W-1:0]  my;
    ptik_pkg::norm_t fold_next;
    ptik_pkg::norm_t fold_reg;
    ptik_pkg::norm_t nrm [0:ptik_pkg::NORM_CELLS];
    ptik_pkg::cst_t  cst [0:STAGES];
    ptik_pkg::cst_t  cst_first;

    // fold into the right half plane
    always_comb begin
        fold_next.zero = (x_in == '0) && (y_in == '0);
        if (x_in < 0) begin
            xf          = -x_in;
            yf          = -y_in;
            fold_next.z = (y_in >= 0) ? ptik_pkg::PI_Q30 : -ptik_pkg::PI_Q30;
        end else begin
            xf          = x_in;
            yf          = y_in;
            fold_next.z = '0;
        end
        fold_next.ny = yf < 0;
        fold_next.ax = $unsigned(xf);
        fold_next.ay = (yf < 0) ? $unsigned(-yf) : $unsigned(yf);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fold_reg <= fold_next;
        end
    end

    assign nrm[0] = fold_reg;

    for (genvar k = 0; k < ptik_pkg::NORM_CELLS; k++) begin : g_norm
        ptik_norm_cell #(
            .SHIFT(1 << (ptik_pkg::NORM_CELLS - 1 - k))
        ) u_norm (
            .aclk (aclk),
            .en   (en),
            .d_in (nrm[k]),
            .d_out(nrm[k+1])
        );
    end

    always_comb begin
        mx             = $signed(ptik_pkg::CX_W'(
                             nrm[ptik_pkg::NORM_CELLS].ax[ptik_pkg::NORM_TOP-1:0]));
        my             = $signed(ptik_pkg::CX_W'(
                             nrm[ptik_pkg::NORM_CELLS].ay[ptik_pkg::NORM_TOP-1:0]));
        cst_first.x    = mx;
        cst_first.y    = nrm[ptik_pkg::NORM_CELLS].ny ? -my : my;
        cst_first.z    = nrm[ptik_pkg::NORM_CELLS].z;
        cst_first.zero = nrm[ptik_pkg::NORM_CELLS].zero;
    end

    assign cst[0] = cst_first;

    for (genvar i = 0; i < STAGES; i++) begin : g_cordic
        ptik_cordic_cell #(
            .IDX(i)
        ) u_cordic (
            .aclk (aclk),
            .en   (en),
            .d_in (cst[i]),
            .d_out(cst[i+1])
        );
    end

    assign z_out = cst[STAGES].zero ? '0 : cst[STAGES].z;
endmodule

// File: rtl/planar_two_link_inverse_kinematics.sv
// Two-link planar arm inverse kinematics, top level.
// Depends on ptik_pkg, ptik_sqrt_cell and ptik_atan2 (with its norm and CORDIC cells).
//
// Usage:
//   s_ channel: one target item (x, y in signed Q8.8) per handshake.
//   m_ channel: one result item per target, in order: the case code on m_tuser,
//   the four joint angles (signed rad; shoulders Q4.13, elbows Q3.13) on m_tdata.
//   cfg channel: writes link length 0 (first) or 1 (second), unsigned Q7.8;
//   always ready, to be used only while the block holds no item.
// Timing:
//   One item per cycle sustained while m_tready is high. Pipeline, in order: the
//   squares, case tests and a split 32x32 product, 31 root cells (one bit per cell),
//   the beta argument registers, 6 + CORDIC_STAGES atan2 cells, the output register.
// Reset (aresetn low, synchronous): pipeline emptied, both links set to 1.0.
// Stall: with m_tvalid high and m_tready low the whole chain freezes; a
//   one-item skid register in front still takes one more target, then
//   s_tready drops until the chain moves again.
module planar_two_link_inverse_kinematics #(
    parameter int CORDIC_STAGES = ptik_pkg::DEF_CORDIC_STAGES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [15:0] target_x, [31:16] target_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,     // [16:0] shoulder_angle_a, [32:17] elbow_angle_a,
                                     // [49:33] shoulder_angle_b, [65:50] elbow_angle_b,
                                     // [71:66] zero
    output logic [2:0]  m_tuser,     // [2:0] solution_kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [14:0] cfg_data
);
    localparam int ATAN_LAT = 1 + ptik_pkg::NORM_CELLS + CORDIC_STAGES;
    localparam int LAT      = 39 + ATAN_LAT;

    // ---------------- control ----------------
    logic [LAT-1:0] vld_reg;
    logic           pipe_en;
    logic           skid_valid_reg;
    logic [31:0]    skid_data_reg;
    logic           src_valid;
    logic [31:0]    src_data;
    logic [14:0]    l1_reg;
    logic [14:0]    l2_reg;

    assign pipe_en   = !vld_reg[LAT-1] || m_tready;
    assign s_tready  = !skid_valid_reg;
    assign src_valid = skid_valid_reg || s_tvalid;
    assign src_data  = skid_valid_reg ? skid_data_reg : s_tdata;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg        <= '0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (pipe_en) begin
                vld_reg        <= {vld_reg[LAT-2:0], src_valid};
                skid_valid_reg <= 1'b0;      // skid item (if any) enters now
            end else if (s_tvalid && !skid_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!pipe_en && s_tvalid && !skid_valid_reg) begin
            skid_data_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1_reg <= ptik_pkg::LINK_RESET;
            l2_reg <= ptik_pkg::LINK_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ptik_pkg::CFG_LINK_FIRST:  l1_reg <= cfg_data;
                ptik_pkg::CFG_LINK_SECOND: l2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage 1: squares and link products ----------------
    logic signed [15:0] x_src;
    logic signed [15:0] y_src;
    logic signed [15:0] x1_reg;
    logic signed [15:0] y1_reg;
    logic signed [31:0] xx1_reg;
    logic signed [31:0] yy1_reg;
    logic [29:0]        ll1_reg;
    logic [29:0]        ll2_reg;
    logic [29:0]        l12_reg;

    assign x_src = $signed(src_data[15:0]);
    assign y_src = $signed(src_data[31:16]);

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            x1_reg  <= x_src;
            y1_reg  <= y_src;
            xx1_reg <= x_src * x_src;
            yy1_reg <= y_src * y_src;
            ll1_reg <= l1_reg * l1_reg;
            ll2_reg <= l2_reg * l2_reg;
            l12_reg <= l1_reg * l2_reg;
        end
    end

    // ---------------- stage 2: r^2, numerator n, denominator d ----------------
    logic [31:0]        r2_next;
    logic signed [33:0] n_next;
    logic signed [15:0] x2_reg;
    logic signed [15:0] y2_reg;
    logic signed [33:0] n2_reg;
    logic [30:0]        d2_reg;
    logic               r2z2_reg;

    always_comb begin
        r2_next = $unsigned(xx1_reg) + $unsigned(yy1_reg);
        n_next  = $signed({2'b00, r2_next}) - $signed({4'b0000, ll1_reg})
                  - $signed({4'b0000, ll2_reg});
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            n2_reg   <= n_next;
            d2_reg   <= {l12_reg, 1'b0};
            r2z2_reg <= r2_next == '0;
        end
    end

    // ---------------- stage 3: exact case tests, d-n and d+n ----------------
    logic signed [33:0] dn;
    logic signed [33:0] am;
    logic signed [33:0] bp;
    ptik_pkg::side_t    side3_next;
    ptik_pkg::side_t    side3_reg;
    logic [31:0]        a3_reg;
    logic [31:0]        b3_reg;

    always_comb begin
        dn = $signed({3'b000, d2_reg});
        am = dn - n2_reg;
        bp = dn + n2_reg;
        priority if (d2_reg == '0 || n2_reg > dn || n2_reg < -dn) begin
            side3_next.kind = ptik_pkg::KIND_UNREACH;
        end else if (n2_reg == dn) begin
            side3_next.kind = ptik_pkg::KIND_STRETCH;
        end else if (n2_reg == -dn && !r2z2_reg) begin
            side3_next.kind = ptik_pkg::KIND_FOLDED;
        end else if (n2_reg == -dn) begin
            side3_next.kind = ptik_pkg::KIND_ORIGIN;
        end else begin
            side3_next.kind = ptik_pkg::KIND_TWO;
        end
        side3_next.x = x2_reg;
        side3_next.y = y2_reg;
        side3_next.n = n2_reg;
        side3_next.d = d2_reg;
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            side3_reg <= side3_next;
            a3_reg    <= am[31:0];
            b3_reg    <= bp[31:0];
        end
    end

    // ---------------- stage 3b: partial products of (d-n)(d+n) ----------------
    ptik_pkg::side_t side3b_reg;
    logic [31:0]     phh_reg;
    logic [31:0]     phl_reg;
    logic [31:0]     plh_reg;
    logic [31:0]     pll_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            side3b_reg <= side3_reg;
            phh_reg    <= a3_reg[31:16] * b3_reg[31:16];
            phl_reg    <= a3_reg[31:16] * b3_reg[15:0];
            plh_reg    <= a3_reg[15:0]  * b3_reg[31:16];
            pll_reg    <= a3_reg[15:0]  * b3_reg[15:0];
        end
    end

    // ---------------- stage 4: radicand d^2 - n^2 ----------------
    logic [63:0]     rad;
    ptik_pkg::sq_t   sq4_next;
    ptik_pkg::sq_t   sq4_reg;
    ptik_pkg::side_t side4_reg;

    always_comb begin
        rad = {phh_reg, 32'h0} + {16'h0, phl_reg, 16'h0} + {16'h0, plh_reg, 16'h0}
              + {32'h0, pll_reg};
        sq4_next.rem  = '0;
        sq4_next.root = '0;
        sq4_next.v    = rad[ptik_pkg::RAD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sq4_reg   <= sq4_next;
            side4_reg <= side3b_reg;
        end
    end

    // ---------------- square-root cell row ----------------
    ptik_pkg::sq_t   sq [0:ptik_pkg::SQRT_CELLS];
    ptik_pkg::side_t side_dl_reg [0:ptik_pkg::SQRT_CELLS-1];

    assign sq[0] = sq4_reg;

    for (genvar j = 0; j < ptik_pkg::SQRT_CELLS; j++) begin : g_sqrt
        ptik_sqrt_cell u_sqrt (
            .aclk (aclk),
            .en   (pipe_en),
            .d_in (sq[j]),
            .d_out(sq[j+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            side_dl_reg[0] <= side4_reg;
            for (int k = 1; k < ptik_pkg::SQRT_CELLS; k++) begin
                side_dl_reg[k] <= side_dl_reg[k-1];
            end
        end
    end

    // ---------------- beta arguments ----------------
    ptik_pkg::side_t      side_sq;
    logic [30:0]          s_root;
    logic [30:0]          s_b1_reg;
    ptik_pkg::side_t      side_b1_reg;
    logic [45:0]          l2s_reg;
    logic [45:0]          l1d_reg;
    logic signed [48:0]   l2n_reg;

    assign side_sq = side_dl_reg[ptik_pkg::SQRT_CELLS-1];
    assign s_root  = sq[ptik_pkg::SQRT_CELLS].root;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s_b1_reg    <= s_root;
            side_b1_reg <= side_sq;
            l2s_reg     <= l2_reg * s_root;
            l1d_reg     <= l1_reg * side_sq.d;
            l2n_reg     <= $signed({1'b0, l2_reg}) * $signed(side_sq.n);
        end
    end

    logic signed [ptik_pkg::ARG_W-1:0] th_y_reg;
    logic signed [ptik_pkg::ARG_W-1:0] th_x_reg;
    logic signed [ptik_pkg::ARG_W-1:0] el_y_reg;
    logic signed [ptik_pkg::ARG_W-1:0] el_x_reg;
    logic signed [ptik_pkg::ARG_W-1:0] be_y_reg;
    logic signed [ptik_pkg::ARG_W-1:0] be_x_reg;
    logic [2:0]                        kind_b2_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            th_y_reg    <= ptik_pkg::ARG_W'(side_b1_reg.y);
            th_x_reg    <= ptik_pkg::ARG_W'(side_b1_reg.x);
            el_y_reg    <= $signed(ptik_pkg::ARG_W'(s_b1_reg));
            el_x_reg    <= ptik_pkg::ARG_W'(side_b1_reg.n);
            be_y_reg    <= $signed(ptik_pkg::ARG_W'(l2s_reg));
            be_x_reg    <= $signed(ptik_pkg::ARG_W'(l1d_reg)) + l2n_reg;
            kind_b2_reg <= side_b1_reg.kind;
        end
    end

    // ---------------- three atan2 chains ----------------
    logic signed [ptik_pkg::ANG_W-1:0] theta;
    logic signed [ptik_pkg::ANG_W-1:0] elbow;
    logic signed [ptik_pkg::ANG_W-1:0] beta;
    logic [2:0]                        kind_dl_reg [0:ATAN_LAT-1];

    ptik_atan2 #(.STAGES(CORDIC_STAGES)) u_theta (
        .aclk(aclk), .en(pipe_en), .y_in(th_y_reg), .x_in(th_x_reg), .z_out(theta)
    );
    ptik_atan2 #(.STAGES(CORDIC_STAGES)) u_elbow (
        .aclk(aclk), .en(pipe_en), .y_in(el_y_reg), .x_in(el_x_reg), .z_out(elbow)
    );
    ptik_atan2 #(.STAGES(CORDIC_STAGES)) u_beta (
        .aclk(aclk), .en(pipe_en), .y_in(be_y_reg), .x_in(be_x_reg), .z_out(beta)
    );

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            kind_dl_reg[0] <= kind_b2_reg;
            for (int k = 1; k < ATAN_LAT; k++) begin
                kind_dl_reg[k] <= kind_dl_reg[k-1];
            end
        end
    end

    // ---------------- output stage: combine, round, select by case ----------------
    logic [2:0]  kind_f;
    logic [16:0] th_q13;
    logic [16:0] sa_q13;
    logic [16:0] sb_q13;
    logic [16:0] el_q13;
    logic [16:0] sa_o;
    logic [15:0] ea_o;
    logic [16:0] sb_o;
    logic [15:0] eb_o;
    logic [71:0] m_tdata_reg;
    logic [2:0]  m_tuser_reg;

    always_comb begin
        kind_f = kind_dl_reg[ATAN_LAT-1];
        th_q13 = ptik_pkg::round_q13((ptik_pkg::ANG_W+1)'(theta));
        sa_q13 = ptik_pkg::round_q13((ptik_pkg::ANG_W+1)'(theta)
                                     - (ptik_pkg::ANG_W+1)'(beta));
        sb_q13 = ptik_pkg::round_q13((ptik_pkg::ANG_W+1)'(theta)
                                     + (ptik_pkg::ANG_W+1)'(beta));
        el_q13 = ptik_pkg::round_q13((ptik_pkg::ANG_W+1)'(elbow));
        sa_o = '0;
        ea_o = '0;
        sb_o = '0;
        eb_o = '0;
        unique case (kind_f)
            ptik_pkg::KIND_STRETCH: begin
                sa_o = th_q13;
            end
            ptik_pkg::KIND_FOLDED: begin
                sa_o = th_q13;
                ea_o = ptik_pkg::ELBOW_PI_Q13;
            end
            ptik_pkg::KIND_TWO: begin
                sa_o = sa_q13;
                ea_o = el_q13[15:0];
                sb_o = sb_q13;
                eb_o = 16'(-el_q13[15:0]);
            end
            default: ;   // unreachable, at origin: all angles zero
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            m_tdata_reg <= {6'b000000, eb_o, sb_o, ea_o, sa_o};
            m_tuser_reg <= kind_f;
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- assertions ----------------
    a_unreach_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ptik_pkg::KIND_UNREACH) |-> (m_tdata[65:0] == '0))
        else $error("unreachable result carries a nonzero angle");

    a_b_only_two: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ptik_pkg::KIND_TWO) |-> (m_tdata[65:33] == '0))
        else $error("second solution set outside the two-solution case");

    a_elbow_mirror: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ptik_pkg::KIND_TWO)
        |-> (m_tdata[65:50] == 16'(-m_tdata[32:17])))
        else $error("elbow angles of the two solutions are not mirrored");

    a_skid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !pipe_en |=> skid_valid_reg)
        else $error("skid item dropped while the chain was frozen");
endmodule
